// File: design/pcs_pkg.sv
// Package for the polyline plane crossing stream.
// Holds the shared widths, register indexes, result kinds and the serial unit status type.
// No dependencies.
package pcs_pkg;

    localparam int DATA_W = 32;
    localparam int NORM_W = 18;
    localparam int TOL_W = 31;
    localparam int DIST_W = 52;
    localparam int FRAC_W = 16;
    localparam int IDX_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_POINTS_DEF = 65536;
    localparam int COORD_BITS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NRM_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NRM_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NRM_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd6;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_INTERVAL = 2'd1;
    localparam logic [1:0] KIND_CROSS = 2'd2;

    typedef logic signed [DATA_W-1:0] t_coord;
    typedef logic signed [NORM_W-1:0] t_norm;
    typedef logic signed [DIST_W-1:0] t_dist;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dot_stat;

endpackage

// File: design/pcs_dot.sv
// Bit-serial dot product of (vertex - origin) with the plane normal.
// Walks the normal one bit a cycle from the sign bit down; depends on pcs_pkg.
module pcs_dot (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  pcs_pkg::t_coord [2:0]      i_v,
    input  pcs_pkg::t_coord [2:0]      i_org,
    input  pcs_pkg::t_norm  [2:0]      i_nrm,
    output pcs_pkg::t_dot_stat         o_stat,
    output pcs_pkg::t_dist             o_d
);
    localparam int CNT_W = $clog2(pcs_pkg::NORM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pcs_pkg::NORM_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    pcs_pkg::t_norm [2:0]        r_nrm;
    pcs_pkg::t_dist              r_acc;
    pcs_pkg::t_dist              n_acc;
    logic signed [pcs_pkg::DATA_W:0] diff [3];
    pcs_pkg::t_dist              term [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = {i_v[k][pcs_pkg::DATA_W-1], i_v[k]}
                    - {i_org[k][pcs_pkg::DATA_W-1], i_org[k]};
            if (!r_nrm[k][pcs_pkg::NORM_W-1]) begin
                term[k] = '0;
            end else if (r_cnt == '0) begin
                term[k] = -pcs_pkg::DIST_W'(diff[k]);
            end else begin
                term[k] = pcs_pkg::DIST_W'(diff[k]);
            end
        end
        n_acc = (r_acc <<< 1) + term[0] + term[1] + term[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_nrm <= i_nrm;
            r_acc <= '0;
        end else if (r_busy) begin
            for (int k = 0; k < 3; k++) begin
                r_nrm[k] <= r_nrm[k] <<< 1;
            end
            r_acc <= n_acc;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_d = r_acc;

endmodule

// File: design/polyline_plane_crossing_stream.sv
// Top level of the polyline plane crossing stream: configuration, run tracking,
// serial crossing divide with interpolation, and the output register. Uses pcs_pkg and pcs_dot.
//
//  Channel   Signals                                  Direction
//  vertex    i_in_valid / o_in_ready, i_vx..i_last_vertex   in
//  result    o_out_valid / i_out_ready, o_kind..o_qz        out
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_data         in
//
// The serial dot product runs over the 18 normal bits; a vertex that completes a crossing then
// runs the divide for 16 steps, each feeding one fraction bit into the three interpolation
// accumulators. Reset is synchronous and active low. A result waits in the output register
// while the next vertex is already taken; a vertex with a result of its own that finds
// that register still full waits in its final step.
module polyline_plane_crossing_stream #(
    parameter int MAX_POINTS = pcs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pcs_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcs_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [pcs_pkg::DATA_W-1:0] i_vx,
    input  logic signed [pcs_pkg::DATA_W-1:0] i_vy,
    input  logic signed [pcs_pkg::DATA_W-1:0] i_vz,
    input  logic                              i_last_vertex,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_kind,
    output logic [pcs_pkg::IDX_W-1:0]         o_start_index,
    output logic [pcs_pkg::IDX_W-1:0]         o_end_index,
    output logic [pcs_pkg::FRAC_W-1:0]        o_edge_fraction,
    output logic signed [pcs_pkg::DATA_W-1:0] o_px,
    output logic signed [pcs_pkg::DATA_W-1:0] o_py,
    output logic signed [pcs_pkg::DATA_W-1:0] o_pz,
    output logic signed [pcs_pkg::DATA_W-1:0] o_qx,
    output logic signed [pcs_pkg::DATA_W-1:0] o_qy,
    output logic signed [pcs_pkg::DATA_W-1:0] o_qz
);
    localparam int CBITS = (COORD_BITS > pcs_pkg::DATA_W) ? pcs_pkg::DATA_W : COORD_BITS;
    localparam int SH = pcs_pkg::DATA_W - CBITS;
    localparam int CNT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_POINTS - 1);
    localparam int DIV_W = pcs_pkg::DIST_W + 1;
    localparam int MUL_W = pcs_pkg::DATA_W + 1 + pcs_pkg::FRAC_W;
    localparam int FCNT_W = $clog2(pcs_pkg::FRAC_W);
    localparam logic [FCNT_W-1:0] FRAC_LAST = FCNT_W'(pcs_pkg::FRAC_W - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DOT = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_DIV = 3'd3;
    localparam logic [2:0] ST_FIN = 3'd4;

    function automatic pcs_pkg::t_coord f_sext(input logic [pcs_pkg::DATA_W-1:0] a);
        f_sext = $signed(a << SH) >>> SH;
    endfunction

    pcs_pkg::t_coord [2:0]        r_org;
    pcs_pkg::t_norm  [2:0]        r_nrm;
    logic [pcs_pkg::TOL_W-1:0]    r_tol;

    logic [2:0]                   r_state;
    pcs_pkg::t_coord [2:0]        r_v;
    logic                         r_last;
    pcs_pkg::t_dist               r_d;
    logic                         r_cur_on;

    logic [CNT_W-1:0]             r_idx;
    logic                         r_prev_valid;
    pcs_pkg::t_coord [2:0]        r_prev_pt;
    pcs_pkg::t_dist               r_prev_d;
    logic                         r_prev_on;
    logic [CNT_W-1:0]             r_rs_idx;
    pcs_pkg::t_coord [2:0]        r_rs_pt;
    logic                         r_many;

    logic [DIV_W-1:0]             r_rem;
    logic [DIV_W-1:0]             r_den;
    logic [pcs_pkg::FRAC_W-1:0]   r_quo;
    logic [FCNT_W-1:0]            r_fcnt;
    logic signed [MUL_W-1:0]      r_mul [3];

    logic                         r_pend;
    logic [1:0]                   r_pk_kind;
    logic [CNT_W-1:0]             r_pk_si;
    logic [CNT_W-1:0]             r_pk_ei;
    logic [pcs_pkg::FRAC_W-1:0]   r_pk_frac;
    pcs_pkg::t_coord [2:0]        r_pk_p;
    pcs_pkg::t_coord [2:0]        r_pk_q;

    logic                         r_ovalid;
    logic [1:0]                   r_o_kind;
    logic [pcs_pkg::IDX_W-1:0]    r_o_si;
    logic [pcs_pkg::IDX_W-1:0]    r_o_ei;
    logic [pcs_pkg::FRAC_W-1:0]   r_o_frac;
    pcs_pkg::t_coord [2:0]        r_o_p;
    pcs_pkg::t_coord [2:0]        r_o_q;

    pcs_pkg::t_dot_stat           dot_stat;
    pcs_pkg::t_dist               dot_d;
    logic                         dot_start;
    logic                         in_acc;
    logic [CNT_W-1:0]             prev_idx;
    logic [pcs_pkg::DIST_W-1:0]   d_mag;
    logic [pcs_pkg::DIST_W-1:0]   pd_mag;
    logic [pcs_pkg::DIST_W-1:0]   tol_sh;
    logic                         n_on;
    logic [DIV_W-1:0]             n_rem2;
    logic                         n_qbit;
    logic signed [MUL_W-1:0]      n_mul [3];
    pcs_pkg::t_coord [2:0]        n_ip;
    logic                         fin_go;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc = i_in_valid && o_in_ready;
    assign dot_start = (r_state == ST_DOT) && !dot_stat.busy && !dot_stat.done;

    pcs_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dot_start),
        .i_v     (r_v),
        .i_org   (r_org),
        .i_nrm   (r_nrm),
        .o_stat  (dot_stat),
        .o_d     (dot_d)
    );

    always_comb begin
        prev_idx = (r_idx == '0) ? CNT_LAST : r_idx - 1'b1;
        d_mag = r_d[pcs_pkg::DIST_W-1] ? pcs_pkg::DIST_W'(-r_d) : pcs_pkg::DIST_W'(r_d);
        pd_mag = r_prev_d[pcs_pkg::DIST_W-1] ? pcs_pkg::DIST_W'(-r_prev_d)
                                             : pcs_pkg::DIST_W'(r_prev_d);
        tol_sh = {{(pcs_pkg::DIST_W - pcs_pkg::TOL_W - 16){1'b0}}, r_tol, 16'd0};
        n_on = (d_mag <= tol_sh);
        n_rem2 = {r_rem[DIV_W-2:0], 1'b0};
        n_qbit = (n_rem2 >= r_den);
        for (int k = 0; k < 3; k++) begin
            n_mul[k] = (r_mul[k] <<< 1)
                     + (n_qbit ? MUL_W'($signed({r_v[k][pcs_pkg::DATA_W-1], r_v[k]})
                                 - $signed({r_prev_pt[k][pcs_pkg::DATA_W-1], r_prev_pt[k]}))
                               : MUL_W'(0));
            n_ip[k] = r_prev_pt[k] + pcs_pkg::DATA_W'(n_mul[k] >>> pcs_pkg::FRAC_W);
        end
        fin_go = !r_pend || !r_ovalid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '0;
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= pcs_pkg::NORM_W'(65536);
            r_tol <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pcs_pkg::REG_ORG_X: r_org[0] <= f_sext(i_cfg_data);
                pcs_pkg::REG_ORG_Y: r_org[1] <= f_sext(i_cfg_data);
                pcs_pkg::REG_ORG_Z: r_org[2] <= f_sext(i_cfg_data);
                pcs_pkg::REG_NRM_X: r_nrm[0] <= i_cfg_data[pcs_pkg::NORM_W-1:0];
                pcs_pkg::REG_NRM_Y: r_nrm[1] <= i_cfg_data[pcs_pkg::NORM_W-1:0];
                pcs_pkg::REG_NRM_Z: r_nrm[2] <= i_cfg_data[pcs_pkg::NORM_W-1:0];
                pcs_pkg::REG_TOL:   r_tol <= i_cfg_data[pcs_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx <= '0;
            r_prev_valid <= 1'b0;
            r_prev_pt <= '0;
            r_prev_d <= '0;
            r_prev_on <= 1'b0;
            r_rs_idx <= '0;
            r_rs_pt <= '0;
            r_many <= 1'b0;
            r_pend <= 1'b0;
            r_ovalid <= 1'b0;
            r_fcnt <= '0;
        end else begin
            if (r_state == ST_FIN && fin_go && r_pend) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_v[0] <= f_sext(i_vx);
                        r_v[1] <= f_sext(i_vy);
                        r_v[2] <= f_sext(i_vz);
                        r_last <= i_last_vertex;
                        r_state <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    if (dot_stat.done) begin
                        r_d <= dot_d;
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_cur_on <= n_on;
                    r_pk_frac <= '0;
                    if (n_on) begin
                        if (r_prev_valid && r_prev_on) begin
                            r_many <= 1'b1;
                            r_pk_kind <= pcs_pkg::KIND_INTERVAL;
                            r_pk_si <= r_rs_idx;
                            r_pk_p <= r_rs_pt;
                        end else begin
                            r_rs_idx <= r_idx;
                            r_rs_pt <= r_v;
                            r_many <= 1'b0;
                            r_pk_kind <= pcs_pkg::KIND_SINGLE;
                            r_pk_si <= r_idx;
                            r_pk_p <= r_v;
                        end
                        r_pk_ei <= r_idx;
                        r_pk_q <= r_v;
                        r_pend <= r_last;
                        r_state <= ST_FIN;
                    end else if (r_prev_valid && r_prev_on) begin
                        r_pend <= 1'b1;
                        r_pk_kind <= r_many ? pcs_pkg::KIND_INTERVAL : pcs_pkg::KIND_SINGLE;
                        r_pk_si <= r_rs_idx;
                        r_pk_ei <= r_many ? prev_idx : r_rs_idx;
                        r_pk_p <= r_rs_pt;
                        r_pk_q <= r_many ? r_prev_pt : r_rs_pt;
                        r_state <= ST_FIN;
                    end else if (r_prev_valid
                                 && (r_prev_d[pcs_pkg::DIST_W-1] != r_d[pcs_pkg::DIST_W-1])) begin
                        r_rem <= {1'b0, pd_mag};
                        r_den <= {1'b0, pd_mag} + {1'b0, d_mag};
                        r_quo <= '0;
                        r_fcnt <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_mul[k] <= '0;
                        end
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_DIV: begin
                    r_rem <= n_qbit ? n_rem2 - r_den : n_rem2;
                    r_quo <= {r_quo[pcs_pkg::FRAC_W-2:0], n_qbit};
                    for (int k = 0; k < 3; k++) begin
                        r_mul[k] <= n_mul[k];
                    end
                    r_fcnt <= r_fcnt + 1'b1;
                    if (r_fcnt == FRAC_LAST) begin
                        r_pend <= 1'b1;
                        r_pk_kind <= pcs_pkg::KIND_CROSS;
                        r_pk_si <= prev_idx;
                        r_pk_ei <= prev_idx;
                        r_pk_frac <= {r_quo[pcs_pkg::FRAC_W-2:0], n_qbit};
                        r_pk_p <= n_ip;
                        r_pk_q <= n_ip;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        if (r_pend) begin
                            r_o_kind <= r_pk_kind;
                            r_o_si <= pcs_pkg::IDX_W'(r_pk_si);
                            r_o_ei <= pcs_pkg::IDX_W'(r_pk_ei);
                            r_o_frac <= r_pk_frac;
                            r_o_p <= r_pk_p;
                            r_o_q <= r_pk_q;
                        end
                        r_pend <= 1'b0;
                        if (r_last) begin
                            r_idx <= '0;
                            r_prev_valid <= 1'b0;
                            r_prev_pt <= '0;
                            r_prev_d <= '0;
                            r_prev_on <= 1'b0;
                            r_rs_idx <= '0;
                            r_rs_pt <= '0;
                            r_many <= 1'b0;
                        end else begin
                            r_idx <= (r_idx == CNT_LAST) ? '0 : r_idx + 1'b1;
                            r_prev_valid <= 1'b1;
                            r_prev_pt <= r_v;
                            r_prev_d <= r_d;
                            r_prev_on <= r_cur_on;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_kind = r_o_kind;
    assign o_start_index = r_o_si;
    assign o_end_index = r_o_ei;
    assign o_edge_fraction = r_o_frac;
    assign o_px = r_o_p[0];
    assign o_py = r_o_p[1];
    assign o_pz = r_o_p[2];
    assign o_qx = r_o_q[0];
    assign o_qy = r_o_q[1];
    assign o_qz = r_o_q[2];

`ifndef SYNTH
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("Vertex taken while the previous one was still in progress.");
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == pcs_pkg::KIND_SINGLE || o_kind == pcs_pkg::KIND_INTERVAL
                         || o_kind == pcs_pkg::KIND_CROSS))
        else $error("Result word carries an undefined kind.");
    a_cross_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == pcs_pkg::KIND_CROSS)
            |-> (o_end_index == o_start_index && o_px == o_qx && o_py == o_qy && o_pz == o_qz))
        else $error("Crossing word has differing start and end.");
    a_run_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != pcs_pkg::KIND_CROSS) |-> (o_edge_fraction == '0))
        else $error("Run word carries a non-zero edge fraction.");
    a_dot_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dot_stat.done |-> (r_state == ST_DOT))
        else $error("Dot product finished outside its step.");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for polyline_plane_crossing_stream.
// Drives vertex words and register writes, predicts every result word and checks it.
// Depends on pcs_pkg and the polyline_plane_crossing_stream RTL.
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic [1:0] kind;
        logic [15:0] start_index;
        logic [15:0] end_index;
        logic [15:0] edge_fraction;
        logic [31:0] px, py, pz, qx, qy, qz;
    } t_hit;

    typedef struct {
        logic [31:0] vx, vy, vz;
        logic last;
        logic typed;
        t_hit hit;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [pcs_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pcs_pkg::DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [pcs_pkg::DATA_W-1:0] i_vx = '0, i_vy = '0, i_vz = '0;
    logic i_last_vertex = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_kind;
    logic [pcs_pkg::IDX_W-1:0] o_start_index, o_end_index;
    logic [pcs_pkg::FRAC_W-1:0] o_edge_fraction;
    logic signed [pcs_pkg::DATA_W-1:0] o_px, o_py, o_pz, o_qx, o_qy, o_qz;

    polyline_plane_crossing_stream uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

    // Plane settings and polyline state of the predictor.
    longint org[3];
    longint nrm[3];
    longint unsigned tol;
    int unsigned vtx_count;
    bit have_prev, prev_on, run_many;
    longint prev_pt[3], run_pt[3];
    longint prev_dist;
    int unsigned run_idx;

    t_hit pending_hits[$];
    int errors = 0;
    int cycle = 0;
    int sent = 0;

    function automatic t_hit make_hit(logic [1:0] kind, int unsigned si, int unsigned ei,
                                      longint unsigned frac, longint p[3], longint q[3]);
        t_hit h;
        h.kind = kind;
        h.start_index = si[15:0];
        h.end_index = ei[15:0];
        h.edge_fraction = frac[15:0];
        h.px = p[0][31:0];
        h.py = p[1][31:0];
        h.pz = p[2][31:0];
        h.qx = q[0][31:0];
        h.qy = q[1][31:0];
        h.qz = q[2][31:0];
        return h;
    endfunction

    function automatic bit plane_step(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                      logic last, output t_hit h);
        longint v[3];
        longint d, ip[3];
        bit on, got;
        longint unsigned a, b, r, q;
        int unsigned idx, pidx;
        v[0] = longint'(signed'(vx));
        v[1] = longint'(signed'(vy));
        v[2] = longint'(signed'(vz));
        idx = vtx_count;
        pidx = (vtx_count + pcs_pkg::MAX_POINTS_DEF - 1) % pcs_pkg::MAX_POINTS_DEF;
        got = 0;
        d = (v[0] - org[0]) * nrm[0] + (v[1] - org[1]) * nrm[1] + (v[2] - org[2]) * nrm[2];
        on = ((d < 0) ? -d : d) <= longint'(tol << 16);
        if (on) begin
            if (have_prev && prev_on) begin
                run_many = 1;
            end else begin
                run_idx = idx;
                run_pt = v;
                run_many = 0;
            end
            if (last) begin
                h = make_hit(run_many ? pcs_pkg::KIND_INTERVAL : pcs_pkg::KIND_SINGLE,
                             run_idx, idx, 0, run_pt, v);
                got = 1;
            end
        end else if (have_prev && prev_on) begin
            h = make_hit(run_many ? pcs_pkg::KIND_INTERVAL : pcs_pkg::KIND_SINGLE, run_idx,
                         run_many ? pidx : run_idx, 0, run_pt, run_many ? prev_pt : run_pt);
            got = 1;
        end else if (have_prev && ((prev_dist < 0) != (d < 0))) begin
            a = (prev_dist < 0) ? -prev_dist : prev_dist;
            b = a + ((d < 0) ? -d : d);
            r = a;
            q = 0;
            for (int i = 0; i < 16; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= b) begin
                    r = r - b;
                    q = q | 1;
                end
            end
            if (q > 65535) q = 65535;
            for (int k = 0; k < 3; k++)
                ip[k] = prev_pt[k] + (((v[k] - prev_pt[k]) * longint'(q)) >>> 16);
            h = make_hit(pcs_pkg::KIND_CROSS, pidx, pidx, q, ip, ip);
            got = 1;
        end
        prev_pt = v;
        prev_dist = d;
        prev_on = on;
        have_prev = 1;
        vtx_count = (vtx_count + 1) % pcs_pkg::MAX_POINTS_DEF;
        if (last) begin
            vtx_count = 0;
            have_prev = 0;
            prev_on = 0;
            prev_dist = 0;
            run_idx = 0;
            run_many = 0;
            prev_pt = '{0, 0, 0};
            run_pt = '{0, 0, 0};
        end
        return got;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_hit w;
        cycle <= cycle + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_hits.size() == 0) begin
                report("unexpected word", o_kind, 0);
            end else begin
                w = pending_hits.pop_front();
                if (o_kind !== w.kind) report("kind", o_kind, w.kind);
                if (o_start_index !== w.start_index)
                    report("start_index", o_start_index, w.start_index);
                if (o_end_index !== w.end_index) report("end_index", o_end_index, w.end_index);
                if (o_edge_fraction !== w.edge_fraction)
                    report("edge_fraction", o_edge_fraction, w.edge_fraction);
                if (o_px !== w.px) report("px", o_px, w.px);
                if (o_py !== w.py) report("py", o_py, w.py);
                if (o_pz !== w.pz) report("pz", o_pz, w.pz);
                if (o_qx !== w.qx) report("qx", o_qx, w.qx);
                if (o_qy !== w.qy) report("qy", o_qy, w.qy);
                if (o_qz !== w.qz) report("qz", o_qz, w.qz);
            end
        end
        if (cycle > 30000 && cycle < 45000) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 99) >= 20);
    end

    task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic last,
                               logic typed, t_hit want);
        t_hit h;
        bit got;
        if (!(sent > 600 && sent < 800)) begin
            while ($urandom_range(0, 99) < 20) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_vx <= vx;
        i_vy <= vy;
        i_vz <= vz;
        i_last_vertex <= last;
        do @(posedge i_clk); while (!o_in_ready);
        got = plane_step(vx, vy, vz, last, h);
        if (typed) h = want;
        if (got) pending_hits = {pending_hits, h};
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending_hits.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pcs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            pcs_pkg::REG_ORG_X: org[0] = longint'(signed'(data));
            pcs_pkg::REG_ORG_Y: org[1] = longint'(signed'(data));
            pcs_pkg::REG_ORG_Z: org[2] = longint'(signed'(data));
            pcs_pkg::REG_NRM_X: nrm[0] = longint'(signed'(data[17:0]));
            pcs_pkg::REG_NRM_Y: nrm[1] = longint'(signed'(data[17:0]));
            pcs_pkg::REG_NRM_Z: nrm[2] = longint'(signed'(data[17:0]));
            pcs_pkg::REG_TOL: tol = data[30:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [17:0] nx, logic [17:0] ny, logic [17:0] nz,
                             logic [31:0] t);
        write_reg(pcs_pkg::REG_ORG_X, ox);
        write_reg(pcs_pkg::REG_ORG_Y, oy);
        write_reg(pcs_pkg::REG_ORG_Z, oz);
        write_reg(pcs_pkg::REG_NRM_X, {{14{nx[17]}}, nx});
        write_reg(pcs_pkg::REG_NRM_Y, {{14{ny[17]}}, ny});
        write_reg(pcs_pkg::REG_NRM_Z, {{14{nz[17]}}, nz});
        write_reg(pcs_pkg::REG_TOL, t);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] near_coord(longint o);
        longint c;
        c = o + longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        return c[31:0];
    endfunction

    function automatic t_row row(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                 logic last);
        t_row r;
        r.vx = vx;
        r.vy = vy;
        r.vz = vz;
        r.last = last;
        r.typed = 0;
        r.hit = '{default: '0};
        return r;
    endfunction

    function automatic t_row typed_row(t_row r, logic [1:0] kind, logic [15:0] si,
                                       logic [15:0] ei, logic [15:0] frac,
                                       logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                       logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
        r.typed = 1;
        r.hit = '{kind, si, ei, frac, px, py, pz, qx, qy, qz};
        return r;
    endfunction

    initial begin
        t_row plan[$];
        logic [31:0] ox, oy, oz, t, vx, vy, vz;
        logic [17:0] nx, ny, nz;
        int len, mode;
        org = '{0, 0, 0};
        nrm = '{0, 0, 65536};
        tol = 0;
        vtx_count = 0;
        have_prev = 0;
        prev_on = 0;
        run_many = 0;
        prev_dist = 0;
        run_idx = 0;
        prev_pt = '{0, 0, 0};
        run_pt = '{0, 0, 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset plane is z = 0 with zero tolerance.
        plan = {plan, typed_row(row(0, 0, 0, 1), pcs_pkg::KIND_SINGLE, 0, 0, 0,
                                0, 0, 0, 0, 0, 0)};
        plan = {plan, typed_row(row(32'h7fffffff, 32'h80000000, 0, 1), pcs_pkg::KIND_SINGLE,
                                0, 0, 0, 32'h7fffffff, 32'h80000000, 0,
                                32'h7fffffff, 32'h80000000, 0)};
        plan = {plan, row(0, 0, 32'hffff0000, 0)};
        plan = {plan, typed_row(row(0, 0, 32'h00010000, 0), pcs_pkg::KIND_CROSS, 0, 0,
                                16'h8000, 0, 0, 0, 0, 0, 0)};
        plan = {plan, row(5, 5, 0, 0)};
        plan = {plan, row(6, 6, 0, 0)};
        plan = {plan, typed_row(row(0, 0, 32'h7fffffff, 0), pcs_pkg::KIND_INTERVAL, 2, 3, 0,
                                5, 5, 0, 6, 6, 0)};
        plan = {plan, row(1, 0, 0, 0)};
        plan = {plan, typed_row(row(0, 0, 32'h80000000, 1), pcs_pkg::KIND_SINGLE, 5, 5, 0,
                                1, 0, 0, 1, 0, 0)};
        plan = {plan, row(32'hffffffff, 32'hffffffff, 32'h7fffffff, 0)};
        plan = {plan, row(32'h80000000, 32'h7fffffff, 32'h80000000, 0)};
        plan = {plan, row(3, 4, 0, 0)};
        plan = {plan, row(7, 8, 0, 1)};
        plan = {plan, row(1, 2, 32'h00000001, 0)};
        plan = {plan, row(9, 9, 32'hffffffff, 0)};
        plan = {plan, row(9, 9, 32'h00000003, 1)};
        foreach (plan[i])
            send_vertex(plan[i].vx, plan[i].vy, plan[i].vz, plan[i].last,
                        plan[i].typed, plan[i].hit);
        drain();

        for (int phase = 0; phase < 14; phase++) begin
            ox = $urandom_range(0, 1 << 20) - (1 << 19);
            oy = $urandom_range(0, 1 << 20) - (1 << 19);
            oz = $urandom_range(0, 1 << 20) - (1 << 19);
            nx = 18'($urandom);
            ny = 18'($urandom);
            nz = 18'($urandom);
            t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 1 << 17);
            t[31] = 1'($urandom);
            case (phase)
                0: begin
                    nx = 18'h20000;
                    ny = 18'h1ffff;
                    nz = 18'h00000;
                    t = 0;
                end
                1: begin
                    nx = 0;
                    ny = 0;
                    nz = 0;
                end
                2: t = 32'hffffffff;
                3: begin
                    ox = 32'h80000000;
                    oy = 32'h7fffffff;
                    oz = 0;
                    t = 32'h7fffffff;
                end
                default: ;
            endcase
            set_plane(ox, oy, oz, nx, ny, nz, t);
            for (int n = 0; n < 100; ) begin
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++) begin
                    mode = $urandom_range(0, 9);
                    if (mode == 0) begin
                        vx = $urandom;
                        vy = $urandom;
                        vz = $urandom;
                    end else if (mode < 3) begin
                        vx = org[0][31:0];
                        vy = org[1][31:0];
                        vz = org[2][31:0];
                    end else begin
                        vx = near_coord(org[0]);
                        vy = near_coord(org[1]);
                        vz = near_coord(org[2]);
                    end
                    send_vertex(vx, vy, vz, (j == len - 1) || ($urandom_range(0, 49) == 0),
                                0, '{default: '0});
                    n++;
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
